// ===== hdl/rvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_pkg
// Shared widths, constants and types for the radial vignette pixel pipeline.
// ----------------------------------------------------------------------------
package rvp_pkg;

  localparam int unsigned MAX_SIDE = 4096;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned HALF_W  = CFG_W - 1;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;
  localparam int unsigned      CFG_MAX    = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] SIDE_CAP   = CFG_W'((MAX_SIDE > CFG_MAX) ? CFG_MAX : MAX_SIDE);

  // distance: sum of squares and its integer root
  localparam int unsigned DIFF_W = HALF_W > COORD_W ? HALF_W : COORD_W;
  localparam int unsigned SQ_W   = 2 * DIFF_W + 1;
  localparam int unsigned ROOT_W = (SQ_W + 1) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned SQRT_STAGES = ROOT_W;

  // falloff in percent
  localparam int unsigned PCT     = 100;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned NUM_W   = ROOT_W + PCT_W;
  localparam int unsigned Q_W     = 7;
  localparam int unsigned DIV_STAGES = Q_W + 1;

  // scaling by keep/100: divide by 100 via reciprocal
  localparam int unsigned PROD_W   = CH_W + PCT_W;
  localparam int unsigned RECIP    = 5243;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned RECIP_SH = 19;
  localparam int unsigned SCL_W    = PROD_W + RECIP_W;

  localparam int unsigned LAT   = 3 + SQRT_STAGES + 1 + DIV_STAGES + 3;
  localparam int unsigned COL_D = LAT - 3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== hdl/rvp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rvp_isqrt (
  input  logic                        clk,
  input  logic [rvp_pkg::SQ_W-1:0]    radicand,
  output logic [rvp_pkg::ROOT_W-1:0]  root
);
  import rvp_pkg::*;

  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_in;
    logic [ROOT_W-1:0] root_nxt;
    logic [RAD_W-1:0]  rad_in;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RAD_W'(radicand);
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    always_comb begin
      rem_sh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial    = (REM_W'(root_in) << 2) | REM_W'(1);
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      rad_r[g]  <= rad_in << 2;
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

// ===== hdl/rvp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_div
// Pipelined falloff divider: keep = 100 - min(100, num / den), one
// quotient bit per stage after an overflow check against 100 * den.
// ----------------------------------------------------------------------------
module rvp_div (
  input  logic                       clk,
  input  logic [rvp_pkg::NUM_W-1:0]  num,
  input  logic [rvp_pkg::NUM_W-1:0]  lim,
  input  logic [rvp_pkg::HALF_W-1:0] den,
  output logic [rvp_pkg::PCT_W-1:0]  keep
);
  import rvp_pkg::*;

  logic [NUM_W-1:0]  rem_r [DIV_STAGES];
  logic [HALF_W-1:0] den_r [DIV_STAGES];
  logic [Q_W-1:0]    q_r   [DIV_STAGES];
  logic              cap_r [DIV_STAGES];

  // zero radius gives lim of zero and so saturates
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    cap_r[0] <= (num >= lim);
  end

  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_stage
    logic [NUM_W-1:0] sub;
    logic             ge;

    always_comb begin
      sub = NUM_W'(den_r[g-1]) << (Q_W - g);
      ge  = !cap_r[g-1] && (rem_r[g-1] >= sub);
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? (rem_r[g-1] - sub) : rem_r[g-1];
      den_r[g] <= den_r[g-1];
      q_r[g]   <= {q_r[g-1][Q_W-2:0], ge};
      cap_r[g] <= cap_r[g-1];
    end
  end

  assign keep = cap_r[DIV_STAGES-1] ? '0
                                    : PCT_W'(PCT) - PCT_W'(q_r[DIV_STAGES-1]);

endmodule

// ===== hdl/radial_vignette_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_vignette_pixel
// Darkens each pixel linearly with its distance from the image centre.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel may be started on every clock and busy is never
// raised. Each result appears on the out_ ports together with out_strobe; the
// receiver cannot stall, so the stream comes out in order at the input rate.
// The pipeline runs through the 13-stage square root (one root bit per stage)
// and the 8-stage falloff divider. Write the image size only while no pixel
// is in flight: a pixel takes the centre at its start and the radius later,
// once its distance has passed the square root.
module radial_vignette_pixel (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvp_pkg::CFG_W-1:0]     cfg_wdata,

  input  logic                          start,
  output logic                          busy,
  input  logic [rvp_pkg::COORD_W-1:0]   in_pixel_x,
  input  logic [rvp_pkg::COORD_W-1:0]   in_pixel_y,
  input  logic [rvp_pkg::CH_W-1:0]      in_red_in,
  input  logic [rvp_pkg::CH_W-1:0]      in_green_in,
  input  logic [rvp_pkg::CH_W-1:0]      in_blue_in,

  output logic                          out_strobe,
  output logic [rvp_pkg::CH_W-1:0]      out_red_out,
  output logic [rvp_pkg::CH_W-1:0]      out_green_out,
  output logic [rvp_pkg::CH_W-1:0]      out_blue_out
);
  import rvp_pkg::*;

  logic [CFG_W-1:0]  width_r;
  logic [CFG_W-1:0]  height_r;
  logic [CFG_W-1:0]  width_sat;
  logic [CFG_W-1:0]  height_sat;
  logic [HALF_W-1:0] half_w;
  logic [HALF_W-1:0] half_h;

  logic              vld_r [LAT];
  rgb_t              col_r [COL_D];

  logic [DIFF_W-1:0] dx_r;
  logic [DIFF_W-1:0] dy_r;
  logic [DIFF_W-1:0] dx_nxt;
  logic [DIFF_W-1:0] dy_nxt;
  logic [SQ_W-1:0]   sqx_r;
  logic [SQ_W-1:0]   sqy_r;
  logic [SQ_W-1:0]   sum_r;
  logic [ROOT_W-1:0] dist_root;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  lim_r;
  logic [HALF_W-1:0] den_r;
  logic [PCT_W-1:0]  keep;
  logic [PROD_W-1:0] prod_r [3];
  logic [SCL_W-1:0]  scl_r  [3];
  logic [CH_W-1:0]   chan   [3];
  rgb_t              col_in;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_sat  = (width_r  > SIDE_CAP) ? SIDE_CAP : width_r;
    height_sat = (height_r > SIDE_CAP) ? SIDE_CAP : height_r;
    half_w     = width_sat[CFG_W-1:1];
    half_h     = height_sat[CFG_W-1:1];
  end

  // valid and colour travel alongside the arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start & !busy;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign col_in = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  always_ff @(posedge clk) begin
    col_r[0] <= col_in;
    for (int i = 1; i < COL_D; i++) col_r[i] <= col_r[i-1];
  end

  always_comb begin
    dx_nxt = (DIFF_W'(in_pixel_x) >= DIFF_W'(half_w)) ? DIFF_W'(in_pixel_x) - DIFF_W'(half_w)
                                                      : DIFF_W'(half_w) - DIFF_W'(in_pixel_x);
    dy_nxt = (DIFF_W'(in_pixel_y) >= DIFF_W'(half_h)) ? DIFF_W'(in_pixel_y) - DIFF_W'(half_h)
                                                      : DIFF_W'(half_h) - DIFF_W'(in_pixel_y);
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
    sum_r <= sqx_r + sqy_r;
  end

  rvp_isqrt u_isqrt (
    .clk      (clk),
    .radicand (sum_r),
    .root     (dist_root)
  );

  always_ff @(posedge clk) begin
    num_r <= NUM_W'(dist_root) * NUM_W'(PCT);
    lim_r <= NUM_W'(half_w) * NUM_W'(PCT);
    den_r <= half_w;
  end

  rvp_div u_div (
    .clk  (clk),
    .num  (num_r),
    .lim  (lim_r),
    .den  (den_r),
    .keep (keep)
  );

  assign chan[0] = col_r[COL_D-1].red;
  assign chan[1] = col_r[COL_D-1].green;
  assign chan[2] = col_r[COL_D-1].blue;

  // c * keep / 100, the divide done as a multiply by 2^19/100
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= PROD_W'(chan[c]) * PROD_W'(keep);
      scl_r[c]  <= SCL_W'(prod_r[c]) * SCL_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    out_red_out   <= scl_r[0][RECIP_SH +: CH_W];
    out_green_out <= scl_r[1][RECIP_SH +: CH_W];
    out_blue_out  <= scl_r[2][RECIP_SH +: CH_W];
  end

  assign out_strobe = vld_r[LAT-1];

endmodule

// ===== tb/radial_vignette_pixel_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_vignette_pixel_check
// Watches the register port and both pixel channels of the vignette block.
// Keeps its own copy of the image size, works out the darkened colour of each
// pixel started and compares every strobed result, in order, field by field.
// ----------------------------------------------------------------------------
module radial_vignette_pixel_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rvp_pkg::COORD_W-1:0]   in_pixel_x,
  input  logic [rvp_pkg::COORD_W-1:0]   in_pixel_y,
  input  logic [rvp_pkg::CH_W-1:0]      in_red_in,
  input  logic [rvp_pkg::CH_W-1:0]      in_green_in,
  input  logic [rvp_pkg::CH_W-1:0]      in_blue_in,
  input  logic                          out_strobe,
  input  logic [rvp_pkg::CH_W-1:0]      out_red_out,
  input  logic [rvp_pkg::CH_W-1:0]      out_green_out,
  input  logic [rvp_pkg::CH_W-1:0]      out_blue_out,
  output int                            fail_count,
  output int                            shade_pending
);
  import rvp_pkg::*;

  logic [CFG_W-1:0] img_w;
  logic [CFG_W-1:0] img_h;
  rgb_t             shade_q[$];

  function automatic rgb_t vignette_shade(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                          logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                          logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                          logic [CH_W-1:0] b);
    int unsigned cx, cy, dx, dy, sq, root, trial, fall, keep;
    rgb_t        shade;
    cx = ((w > MAX_SIDE) ? MAX_SIDE : w) / 2;
    cy = ((h > MAX_SIDE) ? MAX_SIDE : h) / 2;
    dx = (px >= cx) ? px - cx : cx - px;
    dy = (py >= cy) ? py - cy : cy - py;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int k = 14; k >= 0; k--) begin
      trial = root | (32'd1 << k);
      if (trial * trial <= sq) root = trial;
    end
    // zero radius: fully dark
    fall = 100;
    if (cx != 0) begin
      fall = root * 100 / cx;
      if (fall > 100) fall = 100;
    end
    keep = 100 - fall;
    shade.red   = CH_W'(r * keep / 100);
    shade.green = CH_W'(g * keep / 100);
    shade.blue  = CH_W'(b * keep / 100);
    return shade;
  endfunction

  task automatic compare_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      img_w = WIDTH_RST;
      img_h = HEIGHT_RST;
      shade_q.delete();
      fail_count = 0;
    end else begin
      if (out_strobe) begin
        if (shade_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %0d %0d %0d", $time,
                   out_red_out, out_green_out, out_blue_out);
        end else begin
          want = shade_q.pop_front();
          compare_channel("red_out", want.red, out_red_out);
          compare_channel("green_out", want.green, out_green_out);
          compare_channel("blue_out", want.blue, out_blue_out);
        end
      end
      if (start && !busy)
        shade_q.push_back(vignette_shade(img_w, img_h, in_pixel_x, in_pixel_y,
                                         in_red_in, in_green_in, in_blue_in));
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) img_w = cfg_wdata;
        else if (cfg_index == REG_IMAGE_HEIGHT) img_h = cfg_wdata;
      end
    end
    shade_pending = shade_q.size();
  end

endmodule

// ===== tb/radial_vignette_pixel_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_vignette_pixel_test
// Drives pixels and image sizes into the vignette block: a directed set for
// the centre, edges, zero radius and oversized sides, then random pixels over
// random sizes with varying start gaps. The checker judges every result.
// ----------------------------------------------------------------------------
module radial_vignette_pixel_test;
  import rvp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [COORD_W-1:0]   in_pixel_x;
  logic [COORD_W-1:0]   in_pixel_y;
  logic [CH_W-1:0]      in_red_in;
  logic [CH_W-1:0]      in_green_in;
  logic [CH_W-1:0]      in_blue_in;
  logic                 out_strobe;
  logic [CH_W-1:0]      out_red_out;
  logic [CH_W-1:0]      out_green_out;
  logic [CH_W-1:0]      out_blue_out;
  int                   fail_count;
  int                   shade_pending;
  int                   gap_pct;
  int                   stall_cycles;
  int unsigned          cur_w;
  int unsigned          cur_h;

  always #2 clk = ~clk;

  radial_vignette_pixel DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_strobe    (out_strobe),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

  radial_vignette_pixel_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_strobe    (out_strobe),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .fail_count    (fail_count),
    .shade_pending (shade_pending)
  );

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("radial_vignette_pixel_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(int unsigned px, int unsigned py,
                            int unsigned r, int unsigned g, int unsigned b);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_pixel_x  <= COORD_W'(px);
    in_pixel_y  <= COORD_W'(py);
    in_red_in   <= CH_W'(r);
    in_green_in <= CH_W'(g);
    in_blue_in  <= CH_W'(b);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (shade_pending != 0) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain();
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    cur_w = w;
    cur_h = h;
  endtask

  function automatic int unsigned pick_side(int unsigned lo);
    case ($urandom_range(9))
      0:       return $urandom_range(1, 0);
      1:       return $urandom_range(8191, 4097);
      2, 3, 4: return $urandom_range(64, lo);
      default: return $urandom_range(4096, lo);
    endcase
  endfunction

  function automatic int unsigned pick_coord(int unsigned side);
    int unsigned span;
    span = (side > MAX_SIDE) ? MAX_SIDE : side;
    if (span == 0 || $urandom_range(3) == 0) return $urandom_range(4095, 0);
    return $urandom_range(span - 1, 0);
  endfunction

  function automatic int unsigned pick_colour;
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255, 0);
    endcase
  endfunction

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_IMAGE_WIDTH;
    cfg_wdata   = '0;
    start       = 1'b0;
    in_pixel_x  = '0;
    in_pixel_y  = '0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    gap_pct     = 0;
    cur_w       = 32'(WIDTH_RST);
    cur_h       = 32'(HEIGHT_RST);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset size 640 x 480: centre, edges, outside the image
    send_pixel(320, 240, 255, 255, 255);
    send_pixel(0, 0, 255, 0, 255);
    send_pixel(640, 240, 255, 255, 255);
    send_pixel(479, 240, 255, 128, 1);
    send_pixel(4095, 4095, 0, 255, 0);
    send_pixel(4095, 0, 170, 85, 255);
    // zero radius
    set_size(0, 480);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(0, 240, 255, 255, 255);
    set_size(1, 1);
    send_pixel(0, 0, 255, 255, 255);
    // oversized sides saturate
    set_size(8191, 8191);
    send_pixel(2048, 2048, 255, 255, 255);
    send_pixel(0, 4095, 200, 100, 50);
    set_size(4097, 0);
    send_pixel(2048, 0, 255, 255, 255);
    send_pixel(100, 3000, 255, 7, 99);
    // smallest legal and largest legal sides
    set_size(2, 1);
    send_pixel(1, 0, 255, 255, 255);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(2, 0, 255, 255, 255);
    set_size(4096, 4096);
    send_pixel(2048, 2048, 255, 255, 255);
    send_pixel(4095, 4095, 255, 255, 255);
    send_pixel(2048, 0, 255, 254, 253);
    send_pixel(3072, 2048, 255, 255, 255);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 25 : (phase == 1) ? 67 : 0;
      for (int blk = 0; blk < 7; blk++) begin
        set_size(pick_side(2), pick_side(1));
        repeat (33)
          send_pixel(pick_coord(cur_w), pick_coord(cur_h),
                     pick_colour(), pick_colour(), pick_colour());
      end
    end

    drain();
    repeat (LAT + 8) @(negedge clk);
    if (fail_count == 0)
      $display("radial_vignette_pixel_test OK");
    else
      $display("radial_vignette_pixel_test NOT OK");
    $finish;
  end

endmodule

// ===== radial_vignette_pixel.f =====
hdl/rvp_pkg.sv
hdl/rvp_isqrt.sv
hdl/rvp_div.sv
hdl/radial_vignette_pixel.sv
tb/radial_vignette_pixel_check.sv
tb/radial_vignette_pixel_test.sv
